// File: design/cslr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cslr_pkg: shared constants and types for the coordinate-seeded generator
// Holds the mixing constants, field widths, register indexes and the
// sequencer state types.
// ---------------------------------------------------------------------------
package cslr_pkg;

   localparam int XLEN            = 64;
   localparam int MAX_WIDTH       = 31;
   localparam int DRAW_SHIFT      = 24;
   localparam int DRAW_BITS       = XLEN - DRAW_SHIFT;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [XLEN-1:0] MUL_A = 64'h5851_F42D_4C95_7F2D;
   localparam logic [XLEN-1:0] ADD_C = 64'h1405_7B7E_F767_814F;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WORLD_SEED = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAYER_SALT = 1'd1;

   // Index of the final round of each mixing chain.
   localparam logic [1:0] SEED_LAST   = 2'd2;
   localparam logic [1:0] RESEED_LAST = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SALT,
      ST_SEED,
      ST_RESEED,
      ST_DRAW,
      ST_OUT
   } state_type;

   // Steps of one 64-bit product in the mixing unit.
   typedef enum logic [2:0] {
      SUB_LL,
      SUB_LH,
      SUB_HL,
      SUB_ACC,
      SUB_FIN
   } mix_step_type;

endpackage
`default_nettype wire

// File: design/cslr_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cslr_if: request and response channels
// Valid/ready channels carrying a request item and a drawn value.
// ---------------------------------------------------------------------------
interface cslr_req_if;
   import cslr_pkg::*;

   logic                                valid;
   logic                                ready;
   logic                                action;
   logic signed [XLEN-1:0]              pos_x;
   logic signed [XLEN-1:0]              pos_y;
   logic        [MAX_WIDTH-1:0]         max_value;

   modport source (output valid, output action, output pos_x, output pos_y,
                   output max_value, input ready);
   modport sink   (input valid, input action, input pos_x, input pos_y,
                   input max_value, output ready);
endinterface

interface cslr_rsp_if;
   import cslr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [MAX_WIDTH-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// File: design/cslr_mix.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cslr_mix: iterative mixing unit
// Computes v * (v * A + C) + addend modulo 2^64 with one 32x32 multiplier,
// three partial products per 64-bit product.
// ---------------------------------------------------------------------------
module cslr_mix (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [cslr_pkg::XLEN-1:0] v,
   input  wire logic [cslr_pkg::XLEN-1:0] addend,
   output logic                           done,
   output logic [cslr_pkg::XLEN-1:0]      result
);
   import cslr_pkg::*;

   localparam int HALF = XLEN / 2;

   mix_step_type    sub_ff, sub_in;
   logic            phase_ff, phase_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [XLEN-1:0] x_ff, x_in;
   logic [XLEN-1:0] y_ff, y_in;
   logic [XLEN-1:0] add_ff, add_in;
   logic [XLEN-1:0] acc_ff, acc_in;
   logic [XLEN-1:0] mul_ff, mul_in;
   logic [XLEN-1:0] res_ff, res_in;

   logic [HALF-1:0] mul_a;
   logic [HALF-1:0] mul_b;
   logic [XLEN-1:0] add_op;
   logic [XLEN-1:0] sum;

   // Only the low 64 bits of each product matter, so the high-by-high
   // partial product is never formed.
   assign mul_a  = (sub_ff == SUB_HL) ? x_ff[XLEN-1:HALF] : x_ff[HALF-1:0];
   assign mul_b  = (sub_ff == SUB_LH) ? y_ff[XLEN-1:HALF] : y_ff[HALF-1:0];
   assign mul_in = mul_a * mul_b;

   always_comb begin
      if (sub_ff == SUB_FIN) begin
         add_op = phase_ff ? add_ff : ADD_C;
      end else begin
         add_op = {mul_ff[HALF-1:0], {HALF{1'b0}}};
      end
   end

   assign sum = acc_ff + add_op;

   // Next step.
   always_comb begin
      sub_in = sub_ff;
      if (start) begin
         sub_in = SUB_LL;
      end else if (busy_ff) begin
         case (sub_ff)
            SUB_LL:  sub_in = SUB_LH;
            SUB_LH:  sub_in = SUB_HL;
            SUB_HL:  sub_in = SUB_ACC;
            SUB_ACC: sub_in = SUB_FIN;
            SUB_FIN: sub_in = SUB_LL;
            default: sub_in = SUB_LL;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      x_in     = x_ff;
      y_in     = y_ff;
      add_in   = add_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      if (start) begin
         x_in     = v;
         y_in     = MUL_A;
         add_in   = addend;
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         case (sub_ff)
            SUB_LL: begin
               acc_in = acc_ff;
            end
            SUB_LH: begin
               acc_in = mul_ff;
            end
            SUB_HL: begin
               acc_in = sum;
            end
            SUB_ACC: begin
               acc_in = sum;
            end
            SUB_FIN: begin
               if (!phase_ff) begin
                  // The first product plus C becomes the second multiplicand.
                  y_in     = sum;
                  phase_in = 1'b1;
               end else begin
                  res_in  = sum;
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sub_ff   <= sub_in;
      phase_ff <= phase_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      add_ff   <= add_in;
      acc_ff   <= acc_in;
      mul_ff   <= mul_in;
      res_ff   <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

// File: design/cslr_rem.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cslr_rem: bit-serial remainder unit
// Restoring division of the drawn magnitude by the bound, one dividend bit
// per cycle; only the remainder is kept.
// ---------------------------------------------------------------------------
module cslr_rem (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [cslr_pkg::DRAW_BITS-1:0] dividend,
   input  wire logic [cslr_pkg::MAX_WIDTH-1:0] divisor,
   output logic                                busy,
   output logic [cslr_pkg::MAX_WIDTH-1:0]      remainder
);
   import cslr_pkg::*;

   localparam int COUNT_WIDTH = $clog2(DRAW_BITS);

   logic [DRAW_BITS-1:0]   num_ff, num_in;
   logic [MAX_WIDTH-1:0]   div_ff, div_in;
   logic [MAX_WIDTH-1:0]   rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   busy_ff, busy_in;

   logic [MAX_WIDTH:0]     trial;
   logic [MAX_WIDTH+1:0]   diff;

   assign trial = {rem_ff, num_ff[DRAW_BITS-1]};
   assign diff  = {1'b0, trial} - {2'b00, div_ff};

   always_comb begin
      num_in   = num_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         num_in   = dividend;
         div_in   = divisor;
         rem_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DRAW_BITS-2:0], 1'b0};
         // A clear top bit of the difference means the divisor fits.
         if (!diff[MAX_WIDTH+1]) begin
            rem_in = diff[MAX_WIDTH-1:0];
         end else begin
            rem_in = trial[MAX_WIDTH-1:0];
         end
         count_in = count_ff + 1'b1;
         if (count_ff == COUNT_WIDTH'(DRAW_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// File: design/coordinate_seeded_lcg_random.sv
`default_nettype none
// Position request: four mix rounds; ready again once the last round has completed.
// Draw request: the value is set by the 40-step remainder unit, with the mix beside it;
// ready again in the cycle the value turns valid, unless a value waits.
// One request at a time: a new request is taken only once the last one is through.
// A register write restarts the seed chain: six mix rounds.
// Synchronous reset clears all seeds and the running value to zero.
// ---------------------------------------------------------------------------
// coordinate_seeded_lcg_random: position-seeded pseudo-random generator
// A small sequencer drives a shared 64-bit mixing unit and a remainder unit
// to derive layer seeds, reseed from coordinates and draw bounded values.
// ---------------------------------------------------------------------------
module coordinate_seeded_lcg_random (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   cslr_req_if.sink                                  req_chan,
   cslr_rsp_if.source                                rsp_chan,
   input  wire logic                                 csr_write_en,
   input  wire logic [cslr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [cslr_pkg::XLEN-1:0]            csr_wdata
);
   import cslr_pkg::*;

   state_type            state_ff, state_in;
   logic [1:0]           round_ff, round_in;
   logic                 launch_ff, launch_in;
   logic                 mix_got_ff, mix_got_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [XLEN-1:0]      world_seed_ff, world_seed_in;
   logic [XLEN-1:0]      layer_salt_ff, layer_salt_in;
   logic [XLEN-1:0]      mixed_salt_ff, mixed_salt_in;
   logic [XLEN-1:0]      layer_seed_ff, layer_seed_in;
   logic [XLEN-1:0]      running_ff, running_in;
   logic [XLEN-1:0]      work_ff, work_in;
   logic [XLEN-1:0]      pos_x_ff, pos_x_in;
   logic [XLEN-1:0]      pos_y_ff, pos_y_in;
   logic [MAX_WIDTH-1:0] max_ff, max_in;
   logic                 sign_ff, sign_in;
   logic [MAX_WIDTH-1:0] value_ff, value_in;

   logic                 req_accept;
   logic                 req_ready;
   logic                 mix_start;
   logic                 mix_done;
   logic                 mix_take;
   logic [XLEN-1:0]      mix_addend;
   logic [XLEN-1:0]      mix_res;
   logic                 rem_start;
   logic                 rem_busy;
   logic [MAX_WIDTH-1:0] rem_res;
   logic [DRAW_BITS-1:0] draw_t;
   logic [DRAW_BITS-1:0] draw_mag;
   logic [MAX_WIDTH-1:0] draw_value;
   logic                 rsp_free;

   assign req_accept = req_chan.valid && req_ready;
   // A completion that lands while a restart is pending belongs to an
   // abandoned mix and is dropped.
   assign mix_take   = mix_done && !launch_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   assign draw_t   = running_ff[XLEN-1:DRAW_SHIFT];
   assign draw_mag = running_ff[XLEN-1] ? (~draw_t + 1'b1) : draw_t;

   always_comb begin
      if (max_ff == '0) begin
         draw_value = '0;
      end else if (sign_ff && (rem_res != '0)) begin
         draw_value = max_ff - rem_res;
      end else begin
         draw_value = rem_res;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      if (csr_write_en) begin
         state_in = ST_SALT;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_in = req_chan.action ? ST_DRAW : ST_RESEED;
               end
            end
            ST_SALT: begin
               if (mix_take && (round_ff == SEED_LAST)) begin
                  state_in = ST_SEED;
               end
            end
            ST_SEED: begin
               if (mix_take && (round_ff == SEED_LAST)) begin
                  state_in = ST_IDLE;
               end
            end
            ST_RESEED: begin
               if (mix_take && (round_ff == RESEED_LAST)) begin
                  state_in = ST_IDLE;
               end
            end
            ST_DRAW: begin
               if (mix_got_ff && !rem_busy) begin
                  state_in = ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_free) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   // Sequencer outputs.
   always_comb begin
      req_ready  = (state_ff == ST_IDLE) && !csr_write_en;
      mix_start  = launch_ff;
      rem_start  = req_accept && req_chan.action;
      case (state_ff)
         ST_SALT:   mix_addend = layer_salt_ff;
         ST_SEED:   mix_addend = mixed_salt_ff;
         ST_RESEED: mix_addend = round_ff[0] ? pos_y_ff : pos_x_ff;
         default:   mix_addend = layer_seed_ff;
      endcase
   end

   // Datapath next values.
   always_comb begin
      round_in      = round_ff;
      launch_in     = 1'b0;
      mix_got_in    = mix_got_ff;
      world_seed_in = world_seed_ff;
      layer_salt_in = layer_salt_ff;
      mixed_salt_in = mixed_salt_ff;
      layer_seed_in = layer_seed_ff;
      running_in    = running_ff;
      work_in       = work_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      max_in        = max_ff;
      sign_in       = sign_ff;
      if (csr_write_en) begin
         work_in = layer_salt_ff;
         case (csr_index)
            CSR_WORLD_SEED: begin
               world_seed_in = csr_wdata;
            end
            CSR_LAYER_SALT: begin
               layer_salt_in = csr_wdata;
               work_in       = csr_wdata;
            end
            default: begin
               work_in = layer_salt_ff;
            end
         endcase
         round_in  = '0;
         launch_in = 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  pos_x_in   = req_chan.pos_x;
                  pos_y_in   = req_chan.pos_y;
                  max_in     = req_chan.max_value;
                  sign_in    = running_ff[XLEN-1];
                  mix_got_in = 1'b0;
                  round_in   = '0;
                  launch_in  = 1'b1;
                  work_in    = req_chan.action ? running_ff : layer_seed_ff;
               end
            end
            ST_SALT: begin
               if (mix_take) begin
                  launch_in = 1'b1;
                  if (round_ff == SEED_LAST) begin
                     mixed_salt_in = mix_res;
                     work_in       = world_seed_ff;
                     round_in      = '0;
                  end else begin
                     work_in  = mix_res;
                     round_in = round_ff + 1'b1;
                  end
               end
            end
            ST_SEED: begin
               if (mix_take) begin
                  work_in  = mix_res;
                  round_in = round_ff + 1'b1;
                  if (round_ff == SEED_LAST) begin
                     layer_seed_in = mix_res;
                  end else begin
                     launch_in = 1'b1;
                  end
               end
            end
            ST_RESEED: begin
               if (mix_take) begin
                  work_in  = mix_res;
                  round_in = round_ff + 1'b1;
                  if (round_ff == RESEED_LAST) begin
                     running_in = mix_res;
                  end else begin
                     launch_in = 1'b1;
                  end
               end
            end
            ST_DRAW: begin
               if (mix_take) begin
                  running_in = mix_res;
                  mix_got_in = 1'b1;
               end
            end
            default: begin
               mix_got_in = mix_got_ff;
            end
         endcase
      end
   end

   // The response register frees the sequencer once a value is handed over.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      value_in     = value_ff;
      if ((state_ff == ST_OUT) && rsp_free) begin
         rsp_valid_in = 1'b1;
         value_in     = draw_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         round_ff      <= '0;
         launch_ff     <= 1'b0;
         mix_got_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         world_seed_ff <= '0;
         layer_salt_ff <= '0;
         mixed_salt_ff <= '0;
         layer_seed_ff <= '0;
         running_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         round_ff      <= round_in;
         launch_ff     <= launch_in;
         mix_got_ff    <= mix_got_in;
         rsp_valid_ff  <= rsp_valid_in;
         world_seed_ff <= world_seed_in;
         layer_salt_ff <= layer_salt_in;
         mixed_salt_ff <= mixed_salt_in;
         layer_seed_ff <= layer_seed_in;
         running_ff    <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      max_ff   <= max_in;
      sign_ff  <= sign_in;
      value_ff <= value_in;
   end

   cslr_mix u_mix (
      .clock  (clock),
      .reset  (reset),
      .start  (mix_start),
      .v      (work_ff),
      .addend (mix_addend),
      .done   (mix_done),
      .result (mix_res)
   );

   cslr_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (draw_mag),
      .divisor   (req_chan.max_value),
      .busy      (rem_busy),
      .remainder (rem_res)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.value = value_ff;

endmodule
`default_nettype wire

// File: verif/coordinate_seeded_lcg_random_tb_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// coordinate_seeded_lcg_random_tb_pkg: request codes for the generator bench
// Names the two request kinds so that stimulus and checking agree on them.
// ---------------------------------------------------------------------------
package coordinate_seeded_lcg_random_tb_pkg;

   typedef enum logic {
      ACT_RESEED = 1'b0,
      ACT_DRAW   = 1'b1
   } action_type;

endpackage

// File: verif/coordinate_seeded_lcg_random_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// coordinate_seeded_lcg_random_checker: draw predictor and comparator
// Follows register writes and accepted requests with its own copy of the
// seeds and running value, queues the value each draw must return and
// compares every accepted response against the oldest queued value.
// ---------------------------------------------------------------------------
module coordinate_seeded_lcg_random_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   cslr_req_if                                       req_mon,
   cslr_rsp_if                                       rsp_mon,
   input  wire logic                                 csr_write_en,
   input  wire logic [cslr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [cslr_pkg::XLEN-1:0]            csr_wdata,
   output int                                        fail_count,
   output int                                        pending_count,
   output int                                        value_count
);
   import cslr_pkg::*;
   import coordinate_seeded_lcg_random_tb_pkg::*;

   localparam int MAX_REPORTS = 40;

   logic [XLEN-1:0]      world_seed_q;
   logic [XLEN-1:0]      layer_salt_q;
   logic [XLEN-1:0]      mixed_salt_q;
   logic [XLEN-1:0]      layer_seed_q;
   logic [XLEN-1:0]      running_q;
   logic [MAX_WIDTH-1:0] expected_values[$];
   logic [MAX_WIDTH-1:0] oldest_value;
   int                   mismatches = 0;
   int                   values_seen = 0;

   assign fail_count  = mismatches;
   assign value_count = values_seen;

   function automatic logic [XLEN-1:0] lcg_mix(input logic [XLEN-1:0] v,
                                               input logic [XLEN-1:0] addend);
      return v * (v * MUL_A + ADD_C) + addend;
   endfunction

   function automatic logic [MAX_WIDTH-1:0] bounded_draw(input logic [XLEN-1:0] running,
                                                         input logic [MAX_WIDTH-1:0] bound);
      logic signed [XLEN-1:0] shifted;
      logic signed [XLEN-1:0] modulus;
      logic signed [XLEN-1:0] remainder;
      if (bound == '0) begin
         return '0;
      end
      shifted   = $signed(running) >>> DRAW_SHIFT;
      modulus   = $signed({{(XLEN-MAX_WIDTH){1'b0}}, bound});
      // The remainder takes the sign of the dividend; fold it into 0..bound-1.
      remainder = shifted % modulus;
      if (remainder < 0) begin
         remainder = remainder + modulus;
      end
      return remainder[MAX_WIDTH-1:0];
   endfunction

   task automatic refresh_seeds();
      logic [XLEN-1:0] s;
      s = layer_salt_q;
      repeat (3) s = lcg_mix(s, layer_salt_q);
      mixed_salt_q = s;
      s = world_seed_q;
      repeat (3) s = lcg_mix(s, mixed_salt_q);
      layer_seed_q = s;
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatches < MAX_REPORTS) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         world_seed_q = '0;
         layer_salt_q = '0;
         running_q    = '0;
         refresh_seeds();
         expected_values.delete();
      end else begin
         // Responses are checked before a request of the same edge is queued.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_values.size() == 0) begin
               report_mismatch($sformatf("unexpected value %0d", rsp_mon.value));
            end else begin
               oldest_value = expected_values.pop_front();
               values_seen++;
               if (rsp_mon.value !== oldest_value) begin
                  report_mismatch($sformatf("value got %0d expected %0d",
                                            rsp_mon.value, oldest_value));
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_WORLD_SEED: begin
                  world_seed_q = csr_wdata;
               end
               CSR_LAYER_SALT: begin
                  layer_salt_q = csr_wdata;
               end
               default: begin
                  layer_salt_q = layer_salt_q;
               end
            endcase
            refresh_seeds();
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == ACT_RESEED) begin
               running_q = lcg_mix(layer_seed_q, req_mon.pos_x);
               running_q = lcg_mix(running_q, req_mon.pos_y);
               running_q = lcg_mix(running_q, req_mon.pos_x);
               running_q = lcg_mix(running_q, req_mon.pos_y);
            end else begin
               expected_values.push_back(bounded_draw(running_q, req_mon.max_value));
               running_q = lcg_mix(running_q, layer_seed_q);
            end
         end
      end
      pending_count <= expected_values.size();
   end

endmodule

// File: verif/coordinate_seeded_lcg_random_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// coordinate_seeded_lcg_random_tb: testbench top for the seeded generator
// Drives position and draw requests under several seed and salt settings,
// with random gaps on the request side and random response stalls, and
// reports the verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module coordinate_seeded_lcg_random_tb;
   import cslr_pkg::*;
   import coordinate_seeded_lcg_random_tb_pkg::*;

   localparam int QUIET_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 100;
   localparam int RANDOM_REQUESTS = 1000;
   localparam int PHASES          = 8;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [XLEN-1:0]            csr_wdata;
   int                         fail_count;
   int                         pending_count;
   int                         value_count;
   int                         quiet_cycles = 0;
   int                         draws = 0;
   int                         reseeds = 0;
   int                         writes = 0;
   bit                         steady = 1'b0;

   cslr_req_if req_if();
   cslr_rsp_if rsp_if();

   coordinate_seeded_lcg_random uut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   coordinate_seeded_lcg_random_checker draw_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .value_count   (value_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one; none at all in steady phases.
   function automatic int pick_gap();
      int roll;
      if (steady) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 85) begin
         return $urandom_range(1, 3);
      end
      if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [XLEN-1:0] pick_word();
      logic signed [XLEN-1:0] near_zero;
      near_zero = XLEN'($urandom_range(0, 64));
      case ($urandom_range(0, 7))
         0: return {1'b1, {(XLEN-1){1'b0}}};
         1: return {1'b0, {(XLEN-1){1'b1}}};
         2: return '0;
         3: return '1;
         4: return near_zero - 32;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [MAX_WIDTH-1:0] pick_bound();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return MAX_WIDTH'(1);
         3: return MAX_WIDTH'(1) << $urandom_range(0, MAX_WIDTH-1);
         4, 5: return MAX_WIDTH'($urandom_range(1, 16));
         default: return MAX_WIDTH'($urandom);
      endcase
   endfunction

   task automatic send_request(input action_type act, input logic [XLEN-1:0] x,
                               input logic [XLEN-1:0] y, input logic [MAX_WIDTH-1:0] bound);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.action    <= act;
      req_if.pos_x     <= x;
      req_if.pos_y     <= y;
      req_if.max_value <= bound;
      do @(posedge clock); while (!req_if.ready);
      if (act == ACT_DRAW) begin
         draws++;
      end else begin
         reseeds++;
      end
   endtask

   task automatic send_random_request();
      action_type act;
      act = ($urandom_range(0, 9) < 7) ? ACT_DRAW : ACT_RESEED;
      send_request(act, pick_word(), pick_word(), pick_bound());
   endtask

   // Hold the request side until every queued draw has returned, then wait
   // out the settle time; a long one lets the block finish a position request in flight.
   task automatic drain(input int settle);
      @(negedge clock);
      req_if.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (settle) @(negedge clock);
   endtask

   task automatic set_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                               input logic [XLEN-1:0] data);
      drain(SETTLE_CYCLES);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      writes++;
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (steady || $urandom_range(0, 2) != 0) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            repeat (pick_gap()) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write_en || (req_if.valid && req_if.ready)
          || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no request or response accepted for %0d cycles", QUIET_LIMIT);
         $display("coordinate_seeded_lcg_random_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_if.valid     = 1'b0;
      req_if.action    = ACT_RESEED;
      req_if.pos_x     = '0;
      req_if.pos_y     = '0;
      req_if.max_value = '0;
      csr_write_en     = 1'b0;
      csr_index        = CSR_WORLD_SEED;
      csr_wdata        = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Draws straight out of reset run on a zero running value.
      send_request(ACT_DRAW, '0, '0, MAX_WIDTH'(1));
      send_request(ACT_DRAW, '1, '1, '0);
      send_request(ACT_DRAW, '0, '1, '1);
      send_request(ACT_RESEED, '0, '0, '1);
      send_request(ACT_DRAW, '0, '0, MAX_WIDTH'(7));

      set_register(CSR_WORLD_SEED, {1'b1, {(XLEN-1){1'b0}}});
      set_register(CSR_LAYER_SALT, {1'b0, {(XLEN-1){1'b1}}});
      send_request(ACT_RESEED, {1'b1, {(XLEN-1){1'b0}}}, {1'b0, {(XLEN-1){1'b1}}}, '0);
      send_request(ACT_DRAW, '0, '0, '1);
      send_request(ACT_DRAW, '0, '0, '0);
      send_request(ACT_DRAW, '0, '0, MAX_WIDTH'(1));
      send_request(ACT_RESEED, {1'b0, {(XLEN-1){1'b1}}}, {1'b1, {(XLEN-1){1'b0}}}, '1);
      send_request(ACT_DRAW, '0, '0, MAX_WIDTH'(1) << (MAX_WIDTH-1));
      send_request(ACT_DRAW, '0, '0, MAX_WIDTH'(3));

      set_register(CSR_WORLD_SEED, {1'b0, {(XLEN-1){1'b1}}});
      set_register(CSR_LAYER_SALT, {1'b1, {(XLEN-1){1'b0}}});
      send_request(ACT_RESEED, '1, '1, '0);
      send_request(ACT_DRAW, '1, '1, '1);
      send_request(ACT_DRAW, '0, '0, MAX_WIDTH'(2));

      set_register(CSR_WORLD_SEED, '1);
      set_register(CSR_LAYER_SALT, '1);
      send_request(ACT_RESEED, XLEN'(1), '1, '0);
      send_request(ACT_DRAW, '0, '0, MAX_WIDTH'(12345));
      send_request(ACT_DRAW, '0, '0, '1);
      send_request(ACT_RESEED, pick_word(), pick_word(), pick_bound());
      send_request(ACT_DRAW, pick_word(), pick_word(), pick_bound());

      for (int phase = 0; phase < PHASES; phase++) begin
         steady = ($urandom_range(0, 3) == 0);
         if (phase == 0 || $urandom_range(0, 2) != 0) begin
            set_register(CSR_WORLD_SEED, pick_word());
         end
         if (phase == 0 || $urandom_range(0, 2) != 0) begin
            set_register(CSR_LAYER_SALT, pick_word());
         end
         send_request(ACT_RESEED, pick_word(), pick_word(), pick_bound());
         for (int n = 1; n < RANDOM_REQUESTS / PHASES; n++) begin
            if (n == RANDOM_REQUESTS / PHASES / 2) begin
               drain(0);
            end
            send_random_request();
         end
      end

      steady = 1'b0;
      drain(SETTLE_CYCLES);
      $display("Covered %0d position requests and %0d draws (%0d values checked)",
               reseeds, draws, value_count);
      $display("under %0d register writes, with random request gaps and response stalls.",
               writes);
      if (fail_count == 0) begin
         $display("coordinate_seeded_lcg_random_tb OK");
      end else begin
         $display("coordinate_seeded_lcg_random_tb NOT OK");
      end
      $finish;
   end

endmodule
